// ===== rtl/lpc_pkg.sv =====
// Shared constants and types of the LRU page cache.
package lpc_pkg;

	// Fixed geometry of the cache
	localparam int NUM_PAGES   = 256;
	localparam int ENTRIES     = 16;
	localparam int PAGE_W      = $clog2(NUM_PAGES);
	localparam int RANK_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = 5;
	localparam int CAP_W       = 5;
	localparam int CAP_RESET   = 16;

	// Configuration port
	localparam int APB_AW      = 2;
	localparam int APB_DW      = 32;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = '0;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch the request page
		logic lookup;   // register tag match, LRU and free slot
		logic commit;   // apply the update and load the result register
	} lpc_cmd_t;

	// One result transaction
	typedef struct packed {
		logic  hit;
		logic  evicted;
		page_t evicted_page;
		cnt_t  occupancy;
	} lpc_result_t;

endpackage

// ===== rtl/lpc_req_if.sv =====
// Request channel: one page number per transaction.
interface lpc_req_if
	import lpc_pkg::*;
();
	logic  valid;
	logic  ready;
	page_t page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

// ===== rtl/lpc_rsp_if.sv =====
// Response channel: hit, eviction and occupancy per transaction.
interface lpc_rsp_if
	import lpc_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  hit;
	logic  evicted;
	page_t evicted_page;
	cnt_t  occupancy;

	modport source (output valid, output hit, output evicted, output evicted_page,
		output occupancy, input ready);
	modport sink   (input valid, input hit, input evicted, input evicted_page,
		input occupancy, output ready);
endinterface

// ===== rtl/lru_page_cache.sv =====
// Fully associative LRU page cache of 16 entries over 8-bit page numbers.
// Each request transaction yields one response transaction. A request passes
// through capture, a parallel tag compare with LRU and free-slot selection,
// and the rank update; the controller accepts one request at a time, and the
// update waits while the response register is held by backpressure. A new request
// is taken while the previous response still waits. The capacity register
// (reset 16) sets how many entries fill before eviction starts; zero counts
// as 1 and values above 16 as 16. Write it only while no request is in flight.
module lru_page_cache
	import lpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lpc_req_if.sink           req,
	lpc_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	lpc_cmd_t         cmd;
	lpc_result_t      result;
	logic [CAP_W-1:0] capacity_q;
	logic             cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_RESET);
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end
	assign prdata = {{(APB_DW-CAP_W){1'b0}}, capacity_q};

	lpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	lpc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.page_in  (req.page_number),
		.capacity (capacity_q),
		.result   (result)
	);

	assign rsp.hit          = result.hit;
	assign rsp.evicted      = result.evicted;
	assign rsp.evicted_page = result.evicted_page;
	assign rsp.occupancy    = result.occupancy;

endmodule

// ===== rtl/lpc_ctrl.sv =====
// Controller state machine: sequences capture, lookup and update per request.
module lpc_ctrl
	import lpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lpc_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       commit;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	// update only once the result register is free or being emptied
	assign commit    = (state_q == S_UPD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign cmd.capture = accept;
	assign cmd.lookup  = (state_q == S_LOOK);
	assign cmd.commit  = commit;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_LOOK;
			S_LOOK: state_d = S_UPD;
			S_UPD:  if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lpc_dpath.sv =====
// Datapath: entry tags, age ranks, occupancy and the result register.
module lpc_dpath
	import lpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lpc_cmd_t         cmd,
	input  page_t            page_in,
	input  logic [CAP_W-1:0] capacity,
	output lpc_result_t      result
);

	// entry state
	page_t               page_q [ENTRIES];
	rank_t               rank_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	cnt_t                used_q;
	page_t               req_q;

	// lookup stage
	logic [ENTRIES-1:0]  match_s1, lru_s1, slot_s1;
	logic                hit_s1, evict_s1;
	rank_t               hit_rank_s1;
	page_t               evict_page_s1;

	logic [ENTRIES-1:0]  match, lru, avail, slot;
	logic                hit, need_evict;
	rank_t               hit_rank, lru_rank;
	page_t               evict_page;
	cnt_t                eff_cap;
	lpc_result_t         result_q;

	// capacity clamped to 1..ENTRIES
	always_comb begin
		if (capacity == '0) begin
			eff_cap = cnt_t'(1);
		end else if (cnt_t'(capacity) > cnt_t'(ENTRIES)) begin
			eff_cap = cnt_t'(ENTRIES);
		end else begin
			eff_cap = cnt_t'(capacity);
		end
	end

	// parallel tag compare; the LRU entry holds rank used-1
	assign lru_rank = rank_t'(used_q - cnt_t'(1));
	always_comb begin
		hit_rank   = '0;
		evict_page = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (page_q[i] == req_q);
			lru[i]   = valid_q[i] && (rank_q[i] == lru_rank);
			if (match[i]) hit_rank = hit_rank | rank_q[i];
			if (lru[i]) evict_page = evict_page | page_q[i];
		end
	end
	assign hit        = |match;
	assign need_evict = !hit && (used_q >= eff_cap);
	// lowest free entry, counting the one about to be evicted
	assign avail      = ~valid_q | (need_evict ? lru : '0);
	assign slot       = avail & (~avail + {{(ENTRIES-1){1'b0}}, 1'b1});

	// request and lookup registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= page_in;
		end
		if (cmd.lookup) begin
			match_s1      <= match;
			lru_s1        <= lru;
			slot_s1       <= slot;
			hit_s1        <= hit;
			evict_s1      <= need_evict;
			hit_rank_s1   <= hit_rank;
			evict_page_s1 <= need_evict ? evict_page : '0;
		end
	end

	// entry update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_s1) begin
					if (match_s1[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < hit_rank_s1) begin
						rank_q[i] <= rank_q[i] + rank_t'(1);
					end
				end else if (slot_s1[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (evict_s1 && lru_s1[i]) begin
					valid_q[i] <= 1'b0;
					rank_q[i]  <= '0;
				end else if (valid_q[i]) begin
					rank_q[i] <= rank_q[i] + rank_t'(1);
				end
			end
			if (!hit_s1 && !evict_s1) begin
				used_q <= used_q + cnt_t'(1);
			end
		end
	end

	// tag store, written on a miss
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_s1) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_s1[i]) page_q[i] <= req_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.hit          <= hit_s1;
			result_q.evicted      <= evict_s1;
			result_q.evicted_page <= evict_page_s1;
			result_q.occupancy    <= (hit_s1 || evict_s1) ? used_q : used_q + cnt_t'(1);
		end
	end

	assign result = result_q;

endmodule

// ===== dv/lpc_sb_pkg.sv =====
// Scoreboard class for the LRU page cache: predicts each response and checks it.
package lpc_sb_pkg;
	import lpc_pkg::*;

	class lpc_tracker;
		// Shadow copy of the cache contents
		page_t                held_page  [ENTRIES];
		logic                 held_valid [ENTRIES];
		rank_t                age_rank   [ENTRIES];
		cnt_t                 occupancy;
		logic [CAP_W-1:0]     cap_raw;
		lpc_result_t          expected_results[$];
		int unsigned          failures;
		int unsigned          requests;
		int unsigned          hits;
		int unsigned          evictions;

		function new();
			foreach (held_valid[i]) begin
				held_valid[i] = 1'b0;
				held_page[i]  = '0;
				age_rank[i]   = '0;
			end
			occupancy = '0;
			cap_raw   = CAP_W'(CAP_RESET);
			failures  = 0;
			requests  = 0;
			hits      = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			cap_raw = value;
		endfunction

		// Zero counts as one entry, anything above the array size saturates
		function int unsigned cap_limit();
			if (cap_raw == 0)
				return 1;
			if (cap_raw > ENTRIES)
				return ENTRIES;
			return cap_raw;
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction

		// Work out the response for one accepted request and queue it
		function void note_request(page_t page);
			int          found;
			int          victim;
			int          slot;
			rank_t       r;
			lpc_result_t res;
			found  = -1;
			victim = -1;
			slot   = -1;
			res    = '0;
			requests++;
			foreach (held_valid[i]) begin
				if (found < 0 && held_valid[i] && held_page[i] == page)
					found = i;
			end
			if (found >= 0) begin
				// hit: promote to most recent, age the younger entries
				r = age_rank[found];
				foreach (held_valid[i]) begin
					if (held_valid[i] && age_rank[i] < r)
						age_rank[i]++;
				end
				age_rank[found] = '0;
				res.hit = 1'b1;
				hits++;
			end else begin
				// miss: evict the oldest entry once the limit is reached
				if (occupancy >= cap_limit()) begin
					foreach (held_valid[i]) begin
						if (held_valid[i] && (victim < 0 || age_rank[i] > age_rank[victim]))
							victim = i;
					end
					if (victim >= 0) begin
						res.evicted      = 1'b1;
						res.evicted_page = held_page[victim];
						held_valid[victim] = 1'b0;
						age_rank[victim]   = '0;
						if (occupancy > 0)
							occupancy--;
						evictions++;
					end
				end
				foreach (held_valid[i]) begin
					if (slot < 0 && !held_valid[i])
						slot = i;
				end
				if (slot >= 0) begin
					foreach (held_valid[i]) begin
						if (held_valid[i])
							age_rank[i]++;
					end
					held_valid[slot] = 1'b1;
					held_page[slot]  = page;
					age_rank[slot]   = '0;
					occupancy++;
				end
			end
			res.occupancy = occupancy;
			expected_results.push_back(res);
		endfunction

		// Compare one response transaction against the oldest prediction
		function void check_response(lpc_result_t got);
			lpc_result_t want;
			if (expected_results.size() == 0) begin
				$error("response with nothing expected: hit %0b evicted %0b page %0d occ %0d",
					got.hit, got.evicted, got.evicted_page, got.occupancy);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0b, got %0b", want.hit, got.hit);
				failures++;
			end
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
				failures++;
			end
			if (got.evicted_page !== want.evicted_page) begin
				$error("evicted_page: expected %0d, got %0d", want.evicted_page,
					got.evicted_page);
				failures++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				failures++;
			end
		endfunction
	endclass

endpackage

// ===== dv/tb_lru_page_cache.sv =====
// Top-level testbench of the LRU page cache: stimulus, handshakes and final verdict.
module tb_lru_page_cache;
	timeunit 1ns;
	timeprecision 1ps;
	import lpc_pkg::*;
	import lpc_sb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int LATENCY_TAIL  = 8;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 67;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	lpc_req_if req_ch ();
	lpc_rsp_if rsp_ch ();

	lpc_tracker  tracker;
	bit          steady;
	int unsigned cycle_count = 0;
	int unsigned settings_used = 0;

	lru_page_cache u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** lru_page_cache: FAILED **");
			$finish;
		end
	end

	// Request monitor: every accepted transaction feeds the predictor
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			tracker.note_request(req_ch.page_number);
	end

	// Response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_response(lpc_result_t'{rsp_ch.hit, rsp_ch.evicted,
				rsp_ch.evicted_page, rsp_ch.occupancy});
	end

	// Response side: random stall before each transaction
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			@(negedge clk);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && rsp_ch.valid));
		end
	end

	// One request transaction, with a random gap in front
	task automatic send_page(input page_t page);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.page_number <= page;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop sending and wait for every outstanding response
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	// APB write of the capacity register; upper data bits carry noise
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_CAPACITY;
		pwdata  <= ($urandom() & ~APB_DW'(32'h1F)) | APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_capacity(value);
		settings_used++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps [PHASES];
		page_t            base;
		page_t            page;
		int unsigned      window;
		tracker = new();
		phase_caps = '{5'd0, 5'd4, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd16};
		steady             = 1'b0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.page_number = '0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset capacity, extreme pages, hits, fill and eviction
		send_page(8'd0);
		send_page(8'd255);
		send_page(8'd0);
		send_page(8'd255);
		for (int i = 1; i <= 14; i++)
			send_page(page_t'(i));
		send_page(8'd170);
		send_page(8'd85);
		send_page(8'd1);
		send_page(8'd1);

		// Random phases, each under its own capacity setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_capacity(phase_caps[ph]);
			steady = (ph % 3 == 1);
			window = 2 * tracker.cap_limit() + 2;
			base   = page_t'($urandom_range(0, 255));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 15) == 0)
					base = page_t'($urandom_range(0, 255));
				if ($urandom_range(0, 3) == 0)
					page = page_t'($urandom_range(0, 255));
				else
					page = base + page_t'($urandom_range(0, window));
				send_page(page);
				// occasional hold-off until the pipe is empty
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (LATENCY_TAIL) @(posedge clk);
		$display("Ran %0d requests (%0d hits, %0d evictions) over %0d capacity settings.",
			tracker.requests, tracker.hits, tracker.evictions, settings_used + 1);
		if (tracker.failures == 0)
			$display("** lru_page_cache: PASSED **");
		else
			$display("** lru_page_cache: FAILED **");
		$finish;
	end

endmodule
